>>> src/tfcp_pkg.sv
// Package with the word types, frame constants and CRC byte update for the frame packer.
`timescale 1ns / 1ps
`default_nettype none
package tfcp_pkg;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
    } item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_word_t;

    localparam int unsigned IDX_W = 5;

    localparam logic [IDX_W-1:0] IDX_HDR_0     = 5'd0;
    localparam logic [IDX_W-1:0] IDX_HDR_1     = 5'd1;
    localparam logic [IDX_W-1:0] IDX_HDR_2     = 5'd2;
    localparam logic [IDX_W-1:0] IDX_PAY_FIRST = 5'd3;
    localparam logic [IDX_W-1:0] IDX_PAY_LAST  = 5'd14;
    localparam logic [IDX_W-1:0] IDX_CRC_LO    = 5'd15;
    localparam logic [IDX_W-1:0] IDX_CRC_HI    = 5'd16;
    localparam logic [IDX_W-1:0] IDX_TRL_0     = 5'd17;
    localparam logic [IDX_W-1:0] IDX_TRL_1     = 5'd18;
    localparam logic [IDX_W-1:0] IDX_LAST      = 5'd19;

    localparam logic [7:0] CHAR_GT   = 8'h3E;
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_LT   = 8'h3C;

    localparam logic [15:0] CRC_SEED = 16'h00FF;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {t, crc[15:8]} ^ {12'b0, t[7:4]} ^ {5'b0, t, 3'b000};
    endfunction

endpackage
`default_nettype wire

>>> src/telemetry_frame_crc_packer_core.sv
// Top level of the telemetry frame packer: input queue and frame serializer.
// The header byte of a frame reaches the frame port through the queue store and then the
// output word register when the queue and serializer are empty.
// The byte-wide output register sends one byte per cycle while frame_stall is low.
// The queue holds QUEUE_DEPTH words, so new words are taken while a frame is being sent.
// Reset empties the queue, rewinds the byte index, reseeds the CRC and drops frame_valid.
`timescale 1ns / 1ps
`default_nettype none
module telemetry_frame_crc_packer_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire tfcp_pkg::item_t       item,
    output logic                       frame_valid,
    input  wire logic                  frame_stall,
    output tfcp_pkg::frame_word_t      frame
);
    import tfcp_pkg::*;

    logic  head_valid;
    item_t head;
    logic  pop;

    tfcp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item      (item),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop)
    );

    tfcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .frame_valid(frame_valid),
        .frame_stall(frame_stall),
        .frame      (frame)
    );

endmodule
`default_nettype wire

>>> src/tfcp_queue.sv
// Front part: accepts input words into a short queue ahead of the frame serializer.
`timescale 1ns / 1ps
`default_nettype none
module tfcp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire tfcp_pkg::item_t item,
    output logic                head_valid,
    output tfcp_pkg::item_t     head,
    input  wire logic           pop
);
    import tfcp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t            store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             do_pop;

    assign item_stall = (count_reg == CNT_FULL);
    assign push       = item_valid && !item_stall;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("Queue fill count exceeds its depth.");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_FULL) && !do_pop |=> count_reg == CNT_FULL)
        else $error("A full queue lost an entry without a pop.");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !push && !do_pop |=> count_reg == $past(count_reg))
        else $error("Queue fill count changed without a push or a pop.");

endmodule
`default_nettype wire

>>> src/tfcp_back.sv
// Back part: serializes one queued word into a 20-byte frame with its running CRC.
`timescale 1ns / 1ps
`default_nettype none
module tfcp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire tfcp_pkg::item_t     head,
    output logic                     pop,
    output logic                     frame_valid,
    input  wire logic                frame_stall,
    output tfcp_pkg::frame_word_t    frame
);
    import tfcp_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic             valid_reg, valid_next;
    frame_word_t      word_reg, word_next;
    logic             emit;
    logic [95:0]      payload;
    logic [IDX_W-1:0] pay_off;
    logic [7:0]       pay_byte;
    logic [7:0]       cur_byte;

    assign emit    = head_valid && (!valid_reg || !frame_stall);
    assign payload = {head.vel_z, head.vel_y, head.vel_x, head.pos_z, head.pos_y, head.pos_x};
    assign pay_off = idx_reg - IDX_PAY_FIRST;
    assign pay_byte = payload[{pay_off[3:0], 3'b000} +: 8];

    always_comb
    begin
        case (idx_reg) inside
            IDX_HDR_0, IDX_HDR_2:        cur_byte = CHAR_GT;
            IDX_HDR_1, IDX_TRL_1:        cur_byte = CHAR_STAR;
            [IDX_PAY_FIRST:IDX_PAY_LAST]: cur_byte = pay_byte;
            IDX_CRC_LO:                  cur_byte = crc_reg[7:0];
            IDX_CRC_HI:                  cur_byte = crc_reg[15:8];
            IDX_TRL_0, IDX_LAST:         cur_byte = CHAR_LT;
            default:                     cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg && frame_stall;
        word_next  = word_reg;
        pop        = 1'b0;
        if (emit)
        begin
            valid_next           = 1'b1;
            word_next.frame_byte = cur_byte;
            word_next.last_byte  = (idx_reg == IDX_LAST);
            if (idx_reg == IDX_LAST)
            begin
                idx_next = '0;
                pop      = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (idx_reg inside {[IDX_PAY_FIRST:IDX_PAY_LAST]})
            begin
                crc_next = crc_byte(crc_reg, pay_byte);
            end
            else if (idx_reg == IDX_CRC_HI)
            begin
                crc_next = CRC_SEED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            crc_reg   <= CRC_SEED;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign frame_valid = valid_reg;
    assign frame       = word_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LAST)
        else $error("Frame byte index ran past the trailer.");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && word_reg.last_byte |-> idx_reg == IDX_HDR_0)
        else $error("Last byte shown while the frame index did not wrap.");

    a_crc_reseed: assert property (@(posedge clk) disable iff (!rst_n)
        emit && (idx_reg == IDX_CRC_HI) |=> crc_reg == CRC_SEED)
        else $error("CRC was not reseeded after the checksum bytes.");

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the telemetry frame packer with its CRC-16 checksum ahead of the trailer.
`timescale 1ns / 1ps
module tb;
    import tfcp_pkg::*;

    localparam int FRAME_BYTES    = 20;
    localparam int PAYLOAD_BYTES  = 12;
    localparam int IDLE_PCT       = 18;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 25;
    localparam int MAX_REPORTS    = 10;

    localparam logic [15:0] CRC_START = 16'h00FF;
    localparam logic [7:0]  ASCII_GT   = 8'h3E;
    localparam logic [7:0]  ASCII_STAR = 8'h2A;
    localparam logic [7:0]  ASCII_LT   = 8'h3C;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        item_valid  = 1'b0;
    logic        item_stall;
    item_t       item        = '0;
    logic        frame_valid;
    logic        frame_stall = 1'b0;
    frame_word_t frame;

    frame_word_t expected_words[$];
    frame_word_t word_want;
    int          mismatches   = 0;
    int          hold_asks    = 0;
    int          quiet_cycles = 0;
    bit          steady       = 1'b0;

    always #5 clk = ~clk;

    telemetry_frame_crc_packer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

    function automatic logic [15:0] ccitt_update(input logic [15:0] acc, input logic [7:0] data);
        logic [7:0] mix;
        mix = data ^ acc[7:0];
        mix = mix ^ (mix << 4);
        return {mix, acc[15:8]} ^ {12'h000, mix[7:4]} ^ ({8'h00, mix} << 3);
    endfunction

    function automatic logic [7:0] payload_byte(input item_t it, input int k);
        logic [95:0] flat;
        logic [15:0] value;
        flat  = it;
        value = flat[95 - 16 * (k / 2) -: 16];
        return (k % 2 == 0) ? value[7:0] : value[15:8];
    endfunction

    function automatic logic [15:0] payload_crc(input item_t it);
        logic [15:0] acc;
        int          k;
        acc = CRC_START;
        for (k = 0; k < PAYLOAD_BYTES; k++)
            acc = ccitt_update(acc, payload_byte(it, k));
        return acc;
    endfunction

    function automatic void predict_frame(input item_t it);
        logic [7:0]  bytes [FRAME_BYTES];
        logic [15:0] crc;
        frame_word_t w;
        int          k;
        crc      = payload_crc(it);
        bytes[0] = ASCII_GT;
        bytes[1] = ASCII_STAR;
        bytes[2] = ASCII_GT;
        for (k = 0; k < PAYLOAD_BYTES; k++)
            bytes[3 + k] = payload_byte(it, k);
        bytes[15] = crc[7:0];
        bytes[16] = crc[15:8];
        bytes[17] = ASCII_LT;
        bytes[18] = ASCII_STAR;
        bytes[19] = ASCII_LT;
        for (k = 0; k < FRAME_BYTES; k++)
        begin
            w.frame_byte = bytes[k];
            w.last_byte  = (k == FRAME_BYTES - 1);
            expected_words.push_back(w);
        end
    endfunction

    function automatic logic [15:0] pick_value(input int mode);
        case (mode)
            0: return 16'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h7FFF;
                    3: return 16'h8000;
                    default: return 16'h0001;
                endcase
            end
            default: return 16'($urandom_range(0, 16)) - 16'd8;
        endcase
    endfunction

    function automatic item_t random_item();
        logic [95:0] flat;
        int          roll;
        int          mode;
        int          k;
        roll = $urandom_range(0, 9);
        mode = (roll < 6) ? 0 : (roll < 8) ? 1 : 2;
        for (k = 0; k < 6; k++)
            flat[95 - 16 * k -: 16] = pick_value(mode);
        return item_t'(flat);
    endfunction

    task automatic send_item(input item_t it);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        predict_frame(it);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_field_extremes();
        steady = 1'b1;
        send_item({6{16'h0000}});
        send_item({6{16'hFFFF}});
        send_item({6{16'h7FFF}});
        send_item({6{16'h8000}});
        send_item({6{16'h5555}});
        send_item({6{16'hAAAA}});
        send_item({6{16'h00FF}});
        send_item({6{16'hFF00}});
        send_item({16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE});
        wait_drained();
    endtask

    task automatic test_zero_crc_bytes();
        item_t       it;
        logic [15:0] crc;
        steady = 1'b0;
        do
        begin
            it  = random_item();
            crc = payload_crc(it);
        end
        while (crc[7:0] != 8'h00);
        send_item(it);
        do
        begin
            it  = random_item();
            crc = payload_crc(it);
        end
        while (crc[15:8] != 8'h00);
        send_item(it);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int n;
        steady    = 1'b1;
        hold_asks = hold_asks + 1;
        for (n = 0; n < 8; n++)
            send_item(random_item());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int n;
        steady = 1'b1;
        for (n = 0; n < 60; n++)
            send_item(random_item());
        steady = 1'b0;
        for (n = 0; n < 330; n++)
            send_item(random_item());
        wait_drained();
    endtask

    initial
    begin : receiver
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_served + 1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                frame_stall <= 1'b1;
                hold_left   = hold_left - 1;
            end
            else
                frame_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: unexpected frame word byte %h last %b",
                             frame.frame_byte, frame.last_byte);
            end
            else
            begin
                word_want = expected_words.pop_front();
                if (frame.frame_byte !== word_want.frame_byte ||
                    frame.last_byte !== word_want.last_byte)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb: mismatch expected byte %h last %b, got byte %h last %b",
                                 word_want.frame_byte, word_want.last_byte,
                                 frame.frame_byte, frame.last_byte);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (frame_valid && !frame_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: watchdog expired with %0d words outstanding", expected_words.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_zero_crc_bytes();
        test_backpressure();
        test_random_traffic();
        if (mismatches == 0 && expected_words.size() == 0)
            $display("tb: PASS");
        else
        begin
            $display("tb: %0d mismatches, %0d words never arrived",
                     mismatches, expected_words.size());
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
